// ===== rtl/core/zih_pkg.sv =====
// Shared types, constants and the xorshift64 helper function for the Zobrist incremental hasher.
// No dependencies; every other file of the block imports this package.
package zih_pkg;

    localparam int NUM_KEYS    = 781;
    localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
    localparam int HASH_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KEY_IDX_W-1:0] PIECE_STRIDE = KEY_IDX_W'(12);
    localparam logic [KEY_IDX_W-1:0] COLOR_STRIDE = KEY_IDX_W'(6);
    localparam logic [KEY_IDX_W-1:0] SIDE_KEY     = KEY_IDX_W'(768);
    localparam logic [KEY_IDX_W-1:0] CASTLE_BASE  = KEY_IDX_W'(769);
    localparam logic [KEY_IDX_W-1:0] EP_BASE      = KEY_IDX_W'(773);
    localparam logic [KEY_IDX_W-1:0] LAST_KEY     = KEY_IDX_W'(NUM_KEYS - 1);

    localparam logic [HASH_W-1:0] SEED_RESET = 64'hf68e_34a4_e8cc_f09a;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_PIECE  = 3'd1;
    localparam logic [2:0] CMD_SIDE   = 3'd2;
    localparam logic [2:0] CMD_CASTLE = 3'd3;
    localparam logic [2:0] CMD_EP     = 3'd4;
    localparam logic [2:0] CMD_REGEN  = 3'd5;

    // Work classes handed from the front to the back.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_KEY,
        OP_REGEN
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 two_keys;
        logic [KEY_IDX_W-1:0] addr0;
        logic [KEY_IDX_W-1:0] addr1;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [HASH_W-1:0] xorshift64(input logic [HASH_W-1:0] x_in);
        logic [HASH_W-1:0] x;
        x = x_in;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

endpackage

// ===== rtl/core/zih_front.sv =====
// Input side of the hasher: takes items and turns them into key-table work.
// Depends on zih_pkg.
module zih_front
    import zih_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [5:0] s_square,
    input  logic [2:0] s_piece_kind,
    input  logic       s_piece_color,
    input  logic [1:0] s_castle_index,
    input  logic       s_old_ep_valid,
    input  logic [5:0] s_old_ep_square,
    input  logic       s_new_ep_valid,
    input  logic [5:0] s_new_ep_square,
    input  q_status_t  q_status,
    output push_t      push
);

    logic [KEY_IDX_W-1:0] piece_idx;
    logic [KEY_IDX_W-1:0] old_ep_idx;
    logic [KEY_IDX_W-1:0] new_ep_idx;
    entry_t               entry;

    assign s_ready = !q_status.full;

    assign piece_idx = KEY_IDX_W'(s_square) * PIECE_STRIDE
                     + (s_piece_color ? COLOR_STRIDE : '0)
                     + KEY_IDX_W'(s_piece_kind);
    assign old_ep_idx = EP_BASE + KEY_IDX_W'(s_old_ep_square[2:0]);
    assign new_ep_idx = EP_BASE + KEY_IDX_W'(s_new_ep_square[2:0]);

    always_comb begin
        entry.op       = OP_NONE;
        entry.two_keys = 1'b0;
        entry.addr0    = piece_idx;
        entry.addr1    = new_ep_idx;
        unique case (s_cmd)
            CMD_CLEAR: begin
                entry.op = OP_CLEAR;
            end
            CMD_PIECE: begin
                entry.op = OP_KEY;
            end
            CMD_SIDE: begin
                entry.op    = OP_KEY;
                entry.addr0 = SIDE_KEY;
            end
            CMD_CASTLE: begin
                entry.op    = OP_KEY;
                entry.addr0 = CASTLE_BASE + KEY_IDX_W'(s_castle_index);
            end
            CMD_EP: begin
                // The present square goes first; the second read only happens when both are there.
                entry.op       = (s_old_ep_valid || s_new_ep_valid) ? OP_KEY : OP_NONE;
                entry.addr0    = s_old_ep_valid ? old_ep_idx : new_ep_idx;
                entry.two_keys = s_old_ep_valid && s_new_ep_valid;
            end
            CMD_REGEN: begin
                entry.op = OP_REGEN;
            end
            default: begin
                entry.op = OP_NONE;
            end
        endcase
    end

    assign push.valid = s_valid && s_ready;
    assign push.entry = entry;

endmodule

// ===== rtl/core/zih_queue.sv =====
// Short FIFO of decoded work between the front and the back of the hasher.
// Depends on zih_pkg.
module zih_queue
    import zih_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  push_t     push,
    input  logic      pop,
    output entry_t    head,
    output q_status_t q_status
);

    entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push.valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== rtl/core/zih_back.sv =====
// Execution side of the hasher: key memory, table generator, running hash and result register.
// Depends on zih_pkg.
module zih_back
    import zih_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [HASH_W-1:0] cfg_seed,
    input  entry_t            head,
    input  q_status_t         q_status,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [HASH_W-1:0] m_hash
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY0,
        S_KEY1,
        S_REGEN,
        S_HOLD
    } state_t;

    state_t               state_reg,   state_next;
    entry_t               cur_reg,     cur_next;
    logic [HASH_W-1:0]    hash_reg,    hash_next;
    logic [HASH_W-1:0]    gen_reg,     gen_next;
    logic [KEY_IDX_W-1:0] widx_reg,    widx_next;
    logic [HASH_W-1:0]    seed_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [HASH_W-1:0]    m_hash_reg,  m_hash_next;
    logic [HASH_W-1:0]    rd_data_reg;
    logic [HASH_W-1:0]    key_mem [NUM_KEYS];

    logic [KEY_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [HASH_W-1:0]    gen_x;
    logic                 done;
    logic                 out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign gen_x     = xorshift64(gen_reg);
    assign m_valid   = m_valid_reg;
    assign m_hash    = m_hash_reg;

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        hash_next    = hash_reg;
        gen_next     = gen_reg;
        widx_next    = widx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_hash_next  = m_hash_reg;
        pop          = 1'b0;
        done         = 1'b0;
        wr_en        = 1'b0;
        rd_addr      = head.addr0;

        unique case (state_reg)
            S_IDLE: begin
                if (!q_status.empty) begin
                    pop      = 1'b1;
                    cur_next = head;
                    unique case (head.op)
                        OP_CLEAR: begin
                            hash_next = '0;
                            done      = 1'b1;
                        end
                        OP_NONE: begin
                            done = 1'b1;
                        end
                        OP_KEY: begin
                            state_next = S_KEY0;
                        end
                        OP_REGEN: begin
                            gen_next   = seed_reg;
                            widx_next  = '0;
                            state_next = S_REGEN;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_KEY0: begin
                // The first key arrives now; the second read is issued in the same cycle.
                rd_addr   = cur_reg.addr1;
                hash_next = hash_reg ^ rd_data_reg;
                if (cur_reg.two_keys) begin
                    state_next = S_KEY1;
                end else begin
                    done = 1'b1;
                end
            end
            S_KEY1: begin
                hash_next = hash_reg ^ rd_data_reg;
                done      = 1'b1;
            end
            S_REGEN: begin
                wr_en     = 1'b1;
                gen_next  = gen_x;
                widx_next = widx_reg + 1'b1;
                if (widx_reg == LAST_KEY) begin
                    done = 1'b1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hash_next  = hash_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (done) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_hash_next  = hash_next;
                state_next   = S_IDLE;
            end else begin
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            hash_reg    <= '0;
            seed_reg    <= SEED_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            hash_reg    <= hash_next;
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_seed;
            end
        end
        cur_reg    <= cur_next;
        gen_reg    <= gen_next;
        widx_reg   <= widx_next;
        m_hash_reg <= m_hash_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[widx_reg] <= gen_x;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

endmodule

// ===== rtl/core/zobrist_incremental_hasher_unit.sv =====
// Top level of the Zobrist incremental hasher: front decoder, work queue and back end.
// Depends on zih_pkg, zih_front, zih_queue and zih_back.
//
//   channel   direction  handshake            payload
//   s_*       in         s_valid / s_ready    cmd, square, piece, castling, en passant fields
//   m_*       out        m_valid / m_ready    hash
//   cfg_*     in         cfg_valid/cfg_ready  seed
//
// Clear and unused commands finish as they leave the queue; single-key toggles also pass
// through S_KEY0, and an en passant change with both squares through S_KEY0 and S_KEY1;
// the single read port of the key memory sets these. Regenerate writes one key per cycle.
// aresetn is synchronous; it zeroes the hash, reloads the seed and empties the queue.
// A stalled result waits in the output register while the two-entry queue fills up.
module zobrist_incremental_hasher_unit
    import zih_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_seed,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [5:0]  s_square,
    input  logic [2:0]  s_piece_kind,
    input  logic        s_piece_color,
    input  logic [1:0]  s_castle_index,
    input  logic        s_old_ep_valid,
    input  logic [5:0]  s_old_ep_square,
    input  logic        s_new_ep_valid,
    input  logic [5:0]  s_new_ep_square,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash
);

    push_t     push;
    q_status_t q_status;
    entry_t    head;
    logic      pop;

    zih_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_square        (s_square),
        .s_piece_kind    (s_piece_kind),
        .s_piece_color   (s_piece_color),
        .s_castle_index  (s_castle_index),
        .s_old_ep_valid  (s_old_ep_valid),
        .s_old_ep_square (s_old_ep_square),
        .s_new_ep_valid  (s_new_ep_valid),
        .s_new_ep_square (s_new_ep_square),
        .q_status        (q_status),
        .push            (push)
    );

    zih_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    zih_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_seed  (cfg_seed),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hash    (m_hash)
    );

`ifndef SYNTHESIS
    // The front must never write into a full queue.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !push.valid)
        else $error("item pushed into a full work queue");

    // The back must never take work from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.empty |-> !pop)
        else $error("work popped from an empty queue");

    // No result is offered in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== dv/tb_zobrist_incremental_hasher_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for zobrist_incremental_hasher_unit: directed moves, then random moves
// under several seeds and handshake mixes. Depends on zih_pkg and the hasher RTL only.
module tb_zobrist_incremental_hasher_unit;
    import zih_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int DIRECTED_ROWS = 22;
    localparam int PHASES        = 5;
    localparam int REGEN_WAIT    = 820;
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_NS      = 4_000_000;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] square;
        logic [2:0] kind;
        logic       color;
        logic [1:0] castle;
        logic       old_v;
        logic [5:0] old_sq;
        logic       new_v;
        logic [5:0] new_sq;
    } move_t;

    localparam int MOVE_W = $bits(move_t);

    typedef struct {
        move_t       mv;
        bit          known;
        logic [63:0] hash;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_seed = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = '0;
    logic [5:0]  s_square = '0;
    logic [2:0]  s_piece_kind = '0;
    logic        s_piece_color = 1'b0;
    logic [1:0]  s_castle_index = '0;
    logic        s_old_ep_valid = 1'b0;
    logic [5:0]  s_old_ep_square = '0;
    logic        s_new_ep_valid = 1'b0;
    logic [5:0]  s_new_ep_square = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_hash;

    // Predictor state: its own copy of the seed, key table and running hash.
    logic [63:0] seed_shadow = SEED_RESET;
    logic [63:0] pos_hash = '0;
    logic [63:0] key_mem [NUM_KEYS];
    logic [63:0] hash_expected [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic pressure_go = 1'b0;
    logic pressure_done = 1'b0;
    int hold_count = 0;

    int mismatches = 0;
    int moves_sent = 0;
    int regens_sent = 0;
    int hashes_checked = 0;
    int seeds_loaded = 0;

    plan_row_t dir_rows [DIRECTED_ROWS];

    zobrist_incremental_hasher_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_seed        (cfg_seed),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_square        (s_square),
        .s_piece_kind    (s_piece_kind),
        .s_piece_color   (s_piece_color),
        .s_castle_index  (s_castle_index),
        .s_old_ep_valid  (s_old_ep_valid),
        .s_old_ep_square (s_old_ep_square),
        .s_new_ep_valid  (s_new_ep_valid),
        .s_new_ep_square (s_new_ep_square),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hash          (m_hash)
    );

    always #4 aclk = ~aclk;

    function automatic move_t mv(input logic [2:0] cmd, input int sq, input int kind,
                                 input int color, input int castle, input int ov,
                                 input int osq, input int nv, input int nsq);
        move_t m;
        m.cmd    = cmd;
        m.square = 6'(sq);
        m.kind   = 3'(kind);
        m.color  = 1'(color);
        m.castle = 2'(castle);
        m.old_v  = 1'(ov);
        m.old_sq = 6'(osq);
        m.new_v  = 1'(nv);
        m.new_sq = 6'(nsq);
        return m;
    endfunction

    // Applies one move to the predicted position and returns the hash it should report.
    function automatic logic [63:0] next_position_hash(input move_t m);
        logic [63:0] gen;
        int idx;
        case (m.cmd)
            CMD_CLEAR: pos_hash = '0;
            CMD_PIECE: begin
                idx = int'(PIECE_STRIDE) * int'(m.square) + int'(COLOR_STRIDE) * int'(m.color)
                      + int'(m.kind);
                pos_hash ^= key_mem[idx];
            end
            CMD_SIDE:   pos_hash ^= key_mem[int'(SIDE_KEY)];
            CMD_CASTLE: pos_hash ^= key_mem[int'(CASTLE_BASE) + int'(m.castle)];
            CMD_EP: begin
                // Only the file of each square selects a key, so equal files cancel.
                if (m.old_v) pos_hash ^= key_mem[int'(EP_BASE) + int'(m.old_sq[2:0])];
                if (m.new_v) pos_hash ^= key_mem[int'(EP_BASE) + int'(m.new_sq[2:0])];
            end
            CMD_REGEN: begin
                gen = seed_shadow;
                for (int i = 0; i < NUM_KEYS; i++) begin
                    gen ^= gen << 13;
                    gen ^= gen >> 7;
                    gen ^= gen << 17;
                    key_mem[i] = gen;
                end
            end
            default: ;
        endcase
        return pos_hash;
    endfunction

    function automatic move_t random_move();
        move_t m;
        int pick;
        m = MOVE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 1) begin
            m.cmd = CMD_REGEN;
        end else if (pick < 4) begin
            m.cmd = CMD_CLEAR;
        end else if (pick < 7) begin
            m.cmd = ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
        end else if (pick < 45) begin
            m.cmd = CMD_PIECE;
            // Mostly real piece kinds; the out-of-range kinds land on neighboring keys.
            if ($urandom_range(9) != 0) m.kind = 3'($urandom_range(5));
        end else if (pick < 60) begin
            m.cmd = CMD_SIDE;
        end else if (pick < 72) begin
            m.cmd = CMD_CASTLE;
        end else begin
            m.cmd = CMD_EP;
        end
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
        mismatches++;
    endtask

    // Offers one move and records its expected hash once the transfer has happened.
    task automatic offer(input move_t m, input bit known, input logic [63:0] typed);
        logic [63:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= m.cmd;
        s_square        <= m.square;
        s_piece_kind    <= m.kind;
        s_piece_color   <= m.color;
        s_castle_index  <= m.castle;
        s_old_ep_valid  <= m.old_v;
        s_old_ep_square <= m.old_sq;
        s_new_ep_valid  <= m.new_v;
        s_new_ep_square <= m.new_sq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = next_position_hash(m);
        hash_expected.push_back(known ? typed : predicted);
        moves_sent++;
        if (m.cmd == CMD_REGEN) regens_sent++;
    endtask

    task automatic drain(input int tail);
        s_valid <= 1'b0;
        while (hash_expected.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // The seed is only written once the block has gone quiet, including any regeneration.
    task automatic load_seed(input logic [63:0] value);
        drain(REGEN_WAIT);
        cfg_valid <= 1'b1;
        cfg_seed  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        seed_shadow = value;
        seeds_loaded++;
    endtask

    // Result side: random stalls, plus one long hold-off that lets the input side back up.
    always @(posedge aclk) begin
        if (pressure_go && !pressure_done) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) pressure_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        logic [63:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (hash_expected.size() == 0) begin
                report_mismatch("hash with no move pending", '0, m_hash);
            end else begin
                want = hash_expected.pop_front();
                if (m_hash !== want) report_mismatch("hash", want, m_hash);
                hashes_checked++;
            end
        end
    end

    initial begin : stimulus
        int phase_send [PHASES];
        int phase_recv [PHASES];
        int phase_moves [PHASES];
        logic [63:0] phase_seed [PHASES];

        phase_send  = '{0, 76, 0, 29, 0};
        phase_recv  = '{0, 0, 76, 29, 0};
        phase_moves = '{320, 320, 320, 320, 70};
        phase_seed  = '{64'hffff_ffff_ffff_ffff, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, 64'd0};

        // Nothing may read the key table before the first regeneration.
        dir_rows[0]  = '{mv(CMD_CLEAR, 63, 7, 1, 3, 1, 63, 1, 63), 1'b1, 64'd0};
        dir_rows[1]  = '{mv(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 64'd0};
        dir_rows[2]  = '{mv(CMD_SPARE_HI, 21, 3, 1, 2, 1, 9, 0, 44), 1'b1, 64'd0};
        dir_rows[3]  = '{mv(CMD_REGEN, 5, 1, 0, 1, 1, 2, 1, 3), 1'b1, 64'd0};
        dir_rows[4]  = '{mv(CMD_SIDE, 17, 2, 1, 1, 0, 30, 1, 12), 1'b0, 64'd0};
        dir_rows[5]  = '{mv(CMD_SIDE, 40, 6, 0, 2, 1, 31, 0, 7), 1'b1, 64'd0};
        dir_rows[6]  = '{mv(CMD_PIECE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 64'd0};
        dir_rows[7]  = '{mv(CMD_PIECE, 63, 5, 1, 3, 1, 63, 1, 63), 1'b0, 64'd0};
        dir_rows[8]  = '{mv(CMD_PIECE, 63, 7, 1, 0, 0, 0, 0, 0), 1'b0, 64'd0};
        dir_rows[9]  = '{mv(CMD_PIECE, 0, 6, 0, 1, 1, 5, 0, 9), 1'b0, 64'd0};
        dir_rows[10] = '{mv(CMD_CASTLE, 12, 4, 1, 0, 1, 18, 1, 50), 1'b0, 64'd0};
        dir_rows[11] = '{mv(CMD_CASTLE, 33, 2, 0, 1, 0, 0, 0, 0), 1'b0, 64'd0};
        dir_rows[12] = '{mv(CMD_CASTLE, 7, 1, 1, 2, 1, 63, 0, 63), 1'b0, 64'd0};
        dir_rows[13] = '{mv(CMD_CASTLE, 50, 0, 0, 3, 0, 22, 1, 1), 1'b0, 64'd0};
        dir_rows[14] = '{mv(CMD_EP, 9, 3, 0, 2, 1, 0, 0, 63), 1'b0, 64'd0};
        dir_rows[15] = '{mv(CMD_EP, 44, 5, 1, 1, 0, 0, 1, 63), 1'b0, 64'd0};
        dir_rows[16] = '{mv(CMD_EP, 2, 0, 0, 0, 1, 3, 1, 59), 1'b0, 64'd0};
        dir_rows[17] = '{mv(CMD_EP, 27, 4, 1, 3, 1, 8, 1, 55), 1'b0, 64'd0};
        dir_rows[18] = '{mv(CMD_EP, 61, 2, 0, 1, 0, 63, 0, 63), 1'b0, 64'd0};
        dir_rows[19] = '{mv(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 64'd0};
        dir_rows[20] = '{mv(CMD_PIECE, 36, 3, 0, 2, 0, 11, 1, 40), 1'b0, 64'd0};
        dir_rows[21] = '{mv(CMD_REGEN, 63, 7, 1, 3, 1, 63, 1, 63), 1'b0, 64'd0};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer(dir_rows[r].mv, dir_rows[r].known, dir_rows[r].hash);

        for (int p = 0; p < PHASES; p++) begin
            load_seed(phase_seed[p]);
            send_idle_pct = phase_send[p];
            recv_stall_pct <= phase_recv[p];
            if (p == 0) pressure_go <= 1'b1;
            // A new seed only takes effect through a regeneration.
            offer(mv(CMD_REGEN, $urandom_range(63), $urandom_range(7), $urandom_range(1),
                     $urandom_range(3), $urandom_range(1), $urandom_range(63),
                     $urandom_range(1), $urandom_range(63)), 1'b0, 64'd0);
            for (int n = 0; n < phase_moves[p]; n++)
                offer(random_move(), 1'b0, 64'd0);
        end

        drain(REGEN_WAIT);
        $display("Run covered %0d moves including %0d table regenerations, under %0d seeds",
                 moves_sent, regens_sent, seeds_loaded + 1);
        $display("and four handshake mixes with one long result hold-off; %0d hashes checked.",
                 hashes_checked);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Timeout: %0d hashes still pending", hash_expected.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/zih_pkg.sv
rtl/core/zih_front.sv
rtl/core/zih_queue.sv
rtl/core/zih_back.sv
rtl/core/zobrist_incremental_hasher_unit.sv
dv/tb_zobrist_incremental_hasher_unit.sv
